FILE: sv/wbf_pkg.sv
// ----------------------------------------------------------------------------
// wbf_pkg: shared types and constants of the weighted base-pair fold core
// Sizes, command codes and the interval stack interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wbf_pkg;

    localparam int MAX_LEN     = 256;
    localparam int MIN_LOOP    = 3;
    localparam int POS_W       = $clog2(MAX_LEN);
    localparam int LEN_W       = POS_W + 1;
    localparam int SCORE_W     = 16;
    localparam int TOTAL_W     = 23;
    localparam int TABLE_DEPTH = MAX_LEN * MAX_LEN;
    localparam int STACK_DEPTH = 2 * MAX_LEN;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    // One interval of the backtrack: positions lo..hi.
    typedef struct packed {
        pos_t lo;
        pos_t hi;
    } iv_t;

    typedef struct packed {
        logic push;
        logic pop;
        iv_t  push_iv;
    } stk_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        iv_t  top;
    } stk_stat_t;

endpackage

`default_nettype wire

FILE: sv/wbf_score_mem.sv
// ----------------------------------------------------------------------------
// wbf_score_mem: pair score memory
// One write port and one registered read port, addressed by (row, col).
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_score_mem (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire wbf_pkg::pos_t  wrow,
    input  wire wbf_pkg::pos_t  wcol,
    input  wire wbf_pkg::score_t wdata,
    input  wire wbf_pkg::pos_t  rrow,
    input  wire wbf_pkg::pos_t  rcol,
    output wbf_pkg::score_t     rdata
);
    import wbf_pkg::*;

    score_t mem [0:TABLE_DEPTH-1];
    score_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[{wrow, wcol}] <= wdata;
        end
        rdata_reg <= mem[{rrow, rcol}];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/wbf_best_mem.sv
// ----------------------------------------------------------------------------
// wbf_best_mem: best-score table
// One write port and two registered read ports. An entry whose column is not
// more than the minimum loop below its row is never filled and reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_best_mem (
    input  wire logic           clk,
    input  wire logic           we,
    input  wire wbf_pkg::pos_t  wrow,
    input  wire wbf_pkg::pos_t  wcol,
    input  wire wbf_pkg::total_t wdata,
    input  wire wbf_pkg::pos_t  a_row,
    input  wire wbf_pkg::pos_t  a_col,
    input  wire logic           a_zero,
    input  wire wbf_pkg::pos_t  b_row,
    input  wire wbf_pkg::pos_t  b_col,
    output wbf_pkg::total_t     a_data,
    output wbf_pkg::total_t     b_data
);
    import wbf_pkg::*;

    total_t mem [0:TABLE_DEPTH-1];
    total_t a_reg;
    total_t b_reg;
    logic   a_zero_reg;
    logic   b_zero_reg;
    logic   a_near;
    logic   b_near;

    assign a_near = ({1'b0, a_col} + LEN_W'(MIN_LOOP)) >= {1'b0, a_row};
    assign b_near = ({1'b0, b_col} + LEN_W'(MIN_LOOP)) >= {1'b0, b_row};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[{wrow, wcol}] <= wdata;
        end
        a_reg      <= mem[{a_row, a_col}];
        b_reg      <= mem[{b_row, b_col}];
        a_zero_reg <= a_zero | a_near;
        b_zero_reg <= b_near;
    end

    assign a_data = a_zero_reg ? '0 : a_reg;
    assign b_data = b_zero_reg ? '0 : b_reg;

endmodule

`default_nettype wire

FILE: sv/wbf_stack.sv
// ----------------------------------------------------------------------------
// wbf_stack: interval stack of the backtrack
// Push writes at the fill count; pop reads the top into a register that is
// valid on the next cycle. A push onto a full stack is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module wbf_stack (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wbf_pkg::stk_ctrl_t ctrl,
    output wbf_pkg::stk_stat_t      stat
);
    import wbf_pkg::*;

    iv_t                mem [0:STACK_DEPTH-1];
    iv_t                top_reg;
    logic [STACK_AW:0]  count_reg;
    logic [STACK_AW:0]  count_next;
    logic               full;
    logic               empty;
    logic [STACK_AW:0]  count_dec;

    assign full      = count_reg == (STACK_AW+1)'(STACK_DEPTH);
    assign empty     = count_reg == '0;
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.pop && !empty)
        begin
            count_next = count_dec;
        end
        else if (ctrl.push && !full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !full && !ctrl.pop)
        begin
            mem[count_reg[STACK_AW-1:0]] <= ctrl.push_iv;
        end
        top_reg <= mem[count_dec[STACK_AW-1:0]];
    end

    assign stat.empty = empty;
    assign stat.full  = full;
    assign stat.top   = top_reg;

    // The sequencer never pushes and pops in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ctrl.push && ctrl.pop))
        else $error("stack push and pop together");

    // Legal lengths never fill the stack.
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.push |-> !full)
        else $error("push onto full interval stack");

    // A pop takes exactly one entry off the stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.pop && !empty) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("stack count not decremented on pop");

endmodule

`default_nettype wire

FILE: sv/weighted_basepair_fold_core.sv
// ----------------------------------------------------------------------------
// weighted_basepair_fold_core: maximum-weight nested base pairing engine
// Loads pair scores, fills a best-score table by dynamic programming, traces
// back the chosen pairs with an interval stack and answers partner queries.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Handshake
//  --------  ------------------------------------  -------------------------
//  request   cmd, row, col, score, length          taken when start && !busy
//  result    paired, partner, pair_score,          one cycle, marked by done
//            total_score, done_res
//
// Loads stay in the idle state and may follow each other in every cycle.
// A read goes through partner memory, then score memory, then result.
// A run fills the best-score table row by row, testing each split k of
// each (j, i) entry, then traces back the chosen pairs interval by interval;
// one sequencer drives one shared adder and its comparisons against the
// two read ports of the best-score table.
// Reset clears the sequencer, the interval stack and every partner valid
// bit. The receiver cannot stall: results are registered and shown once.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_basepair_fold_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       cmd,
    input  wire wbf_pkg::pos_t    row,
    input  wire wbf_pkg::pos_t    col,
    input  wire wbf_pkg::score_t  score,
    input  wire wbf_pkg::len_t    length,
    output logic                  done,
    output logic                  paired,
    output wbf_pkg::pos_t         partner,
    output wbf_pkg::score_t       pair_score,
    output wbf_pkg::total_t       total_score,
    output logic                  done_res
);
    import wbf_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [17:0] {
        S_IDLE     = 18'b000000000000000001,
        S_RD1      = 18'b000000000000000010,
        S_RD2      = 18'b000000000000000100,
        S_F_J      = 18'b000000000000001000,
        S_F_I      = 18'b000000000000010000,
        S_F_K      = 18'b000000000000100000,
        S_F_RD     = 18'b000000000001000000,
        S_F_ADD    = 18'b000000000010000000,
        S_F_KEEP   = 18'b000000000100000000,
        S_TB_INIT  = 18'b000000001000000000,
        S_TB_TOTAL = 18'b000000010000000000,
        S_TB_POP   = 18'b000000100000000000,
        S_TB_POPW  = 18'b000001000000000000,
        S_TB_T1    = 18'b000010000000000000,
        S_TB_T2    = 18'b000100000000000000,
        S_TB_PAIR  = 18'b001000000000000000,
        S_TB_SK    = 18'b010000000000000000,
        S_TB_SPLIT = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    // Loop indices carry one spare bit so that they can reach the length.
    len_t   j_reg, j_next;
    len_t   i_reg, i_next;
    len_t   k_reg, k_next;
    len_t   len_reg, len_next;
    len_t   run_length_reg, run_length_next;
    total_t best_reg, best_next;
    total_t acc_reg, acc_next;
    total_t here_reg, here_next;
    total_t total_reg, total_next;
    score_t s_reg, s_next;
    pos_t   q_row_reg, q_row_next;
    pos_t   p_reg, p_next;
    logic   hit_reg, hit_next;

    // Result registers.
    logic   done_reg, done_next;
    logic   paired_reg, paired_next;
    pos_t   partner_reg, partner_next;
    score_t pair_score_reg, pair_score_next;
    total_t total_score_reg, total_score_next;
    logic   done_res_reg, done_res_next;

    // Memory controls.
    logic   sm_we;
    pos_t   sm_rrow, sm_rcol;
    score_t sm_rdata;
    logic   bm_we;
    total_t bm_wdata;
    pos_t   bm_a_row, bm_a_col, bm_b_row, bm_b_col;
    logic   bm_a_zero;
    total_t bm_a, bm_b;

    stk_ctrl_t stk_ctrl;
    stk_stat_t stk_stat;

    // Partner memory with one valid flop per position.
    pos_t   pt_mem [0:MAX_LEN-1];
    logic [MAX_LEN-1:0] pt_valid_reg;
    logic   pt_clear;
    logic   pt_we;
    pos_t   pt_waddr, pt_wdata;
    pos_t   pt_raddr;
    pos_t   pt_rd_reg;
    logic   pt_vrd_reg;

    // Shared adder and its comparisons.
    total_t add_a, add_b, add_sum;
    logic   sum_eq_here;
    logic   sum_gt_best;

    // Index arithmetic.
    len_t   jm1, ip1, kp1, km1;
    len_t   clamped_len;
    logic   rd_hit;
    pos_t   rd_hi, rd_lo;

    assign add_sum     = add_a + add_b;
    assign sum_eq_here = add_sum == here_reg;
    assign sum_gt_best = add_sum > best_reg;

    assign jm1 = j_reg - LEN_W'(1);
    assign ip1 = i_reg + LEN_W'(1);
    assign kp1 = k_reg + LEN_W'(1);
    assign km1 = k_reg - LEN_W'(1);

    assign clamped_len = (length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length;

    assign rd_hit = pt_vrd_reg && ({1'b0, q_row_reg} < run_length_reg);
    assign rd_hi  = (pt_rd_reg > q_row_reg) ? pt_rd_reg : q_row_reg;
    assign rd_lo  = (pt_rd_reg > q_row_reg) ? q_row_reg : pt_rd_reg;

    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        len_next        = len_reg;
        run_length_next = run_length_reg;
        best_next       = best_reg;
        acc_next        = acc_reg;
        here_next       = here_reg;
        total_next      = total_reg;
        s_next          = s_reg;
        q_row_next      = q_row_reg;
        p_next          = p_reg;
        hit_next        = hit_reg;

        done_next        = 1'b0;
        paired_next      = paired_reg;
        partner_next     = partner_reg;
        pair_score_next  = pair_score_reg;
        total_score_next = total_score_reg;
        done_res_next    = done_res_reg;

        sm_we     = 1'b0;
        sm_rrow   = '0;
        sm_rcol   = '0;
        bm_we     = 1'b0;
        bm_wdata  = '0;
        bm_a_row  = '0;
        bm_a_col  = '0;
        bm_a_zero = 1'b0;
        bm_b_row  = '0;
        bm_b_col  = '0;
        pt_clear  = 1'b0;
        pt_we     = 1'b0;
        pt_waddr  = '0;
        pt_wdata  = '0;
        pt_raddr  = '0;
        add_a     = '0;
        add_b     = '0;
        stk_ctrl  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_LOAD:
                        begin
                            sm_we            = col < row;
                            done_next        = 1'b1;
                            paired_next      = 1'b0;
                            partner_next     = '0;
                            pair_score_next  = '0;
                            total_score_next = '0;
                            done_res_next    = 1'b1;
                        end
                        CMD_RUN:
                        begin
                            len_next        = clamped_len;
                            run_length_next = clamped_len;
                            pt_clear        = 1'b1;
                            j_next          = '0;
                            state_next      = S_F_J;
                        end
                        CMD_READ:
                        begin
                            q_row_next = row;
                            pt_raddr   = row;
                            state_next = S_RD1;
                        end
                        default:
                        begin
                            done_next        = 1'b1;
                            paired_next      = 1'b0;
                            partner_next     = '0;
                            pair_score_next  = '0;
                            total_score_next = '0;
                            done_res_next    = 1'b0;
                        end
                    endcase
                end
            end

            S_RD1:
            begin
                hit_next   = rd_hit;
                p_next     = pt_rd_reg;
                sm_rrow    = rd_hi;
                sm_rcol    = rd_lo;
                state_next = S_RD2;
            end

            S_RD2:
            begin
                done_next        = 1'b1;
                paired_next      = hit_reg;
                partner_next     = hit_reg ? p_reg : '0;
                pair_score_next  = hit_reg ? sm_rdata : '0;
                total_score_next = '0;
                done_res_next    = 1'b1;
                state_next       = S_IDLE;
            end

            // Fill: rows in ascending order, columns ascending within a row.
            S_F_J:
            begin
                i_next = '0;
                if (j_reg >= len_reg)
                begin
                    state_next = S_TB_INIT;
                end
                else
                begin
                    state_next = S_F_I;
                end
            end

            S_F_I:
            begin
                if (i_reg + LEN_W'(MIN_LOOP) < j_reg)
                begin
                    best_next  = '0;
                    k_next     = i_reg;
                    state_next = S_F_K;
                end
                else
                begin
                    j_next     = j_reg + LEN_W'(1);
                    state_next = S_F_J;
                end
            end

            S_F_K:
            begin
                if (k_reg + LEN_W'(MIN_LOOP) < j_reg)
                begin
                    sm_rrow   = j_reg[POS_W-1:0];
                    sm_rcol   = k_reg[POS_W-1:0];
                    bm_a_row  = km1[POS_W-1:0];
                    bm_a_col  = i_reg[POS_W-1:0];
                    bm_a_zero = k_reg == '0;
                    bm_b_row  = jm1[POS_W-1:0];
                    bm_b_col  = kp1[POS_W-1:0];
                    state_next = S_F_RD;
                end
                else
                begin
                    bm_a_row   = jm1[POS_W-1:0];
                    bm_a_col   = i_reg[POS_W-1:0];
                    state_next = S_F_KEEP;
                end
            end

            S_F_RD:
            begin
                add_a      = bm_a;
                add_b      = bm_b;
                acc_next   = add_sum;
                s_next     = sm_rdata;
                state_next = S_F_ADD;
            end

            S_F_ADD:
            begin
                add_a = acc_reg;
                add_b = TOTAL_W'(s_reg);
                if ((s_reg != '0) && sum_gt_best)
                begin
                    best_next = add_sum;
                end
                k_next     = kp1;
                state_next = S_F_K;
            end

            S_F_KEEP:
            begin
                bm_we      = 1'b1;
                bm_wdata   = (bm_a > best_reg) ? bm_a : best_reg;
                i_next     = ip1;
                state_next = S_F_I;
            end

            // Traceback.
            S_TB_INIT:
            begin
                if (len_reg == '0)
                begin
                    total_next = '0;
                    state_next = S_TB_POP;
                end
                else
                begin
                    bm_a_row             = len_reg[POS_W-1:0] - 1'b1;
                    bm_a_col             = '0;
                    stk_ctrl.push        = 1'b1;
                    stk_ctrl.push_iv.lo  = '0;
                    stk_ctrl.push_iv.hi  = len_reg[POS_W-1:0] - 1'b1;
                    state_next           = S_TB_TOTAL;
                end
            end

            S_TB_TOTAL:
            begin
                total_next = bm_a;
                state_next = S_TB_POP;
            end

            S_TB_POP:
            begin
                if (stk_stat.empty)
                begin
                    done_next        = 1'b1;
                    paired_next      = 1'b0;
                    partner_next     = '0;
                    pair_score_next  = '0;
                    total_score_next = total_reg;
                    done_res_next    = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    stk_ctrl.pop = 1'b1;
                    state_next   = S_TB_POPW;
                end
            end

            S_TB_POPW:
            begin
                i_next = {1'b0, stk_stat.top.lo};
                j_next = {1'b0, stk_stat.top.hi};
                if (stk_stat.top.lo >= stk_stat.top.hi)
                begin
                    state_next = S_TB_POP;
                end
                else
                begin
                    bm_a_row   = stk_stat.top.hi;
                    bm_a_col   = stk_stat.top.lo;
                    bm_b_row   = stk_stat.top.hi;
                    bm_b_col   = stk_stat.top.lo + 1'b1;
                    state_next = S_TB_T1;
                end
            end

            S_TB_T1:
            begin
                here_next = bm_a;
                if (bm_b == bm_a)
                begin
                    stk_ctrl.push       = 1'b1;
                    stk_ctrl.push_iv.lo = ip1[POS_W-1:0];
                    stk_ctrl.push_iv.hi = j_reg[POS_W-1:0];
                    state_next          = S_TB_POP;
                end
                else
                begin
                    bm_a_row   = jm1[POS_W-1:0];
                    bm_a_col   = i_reg[POS_W-1:0];
                    bm_b_row   = jm1[POS_W-1:0];
                    bm_b_col   = ip1[POS_W-1:0];
                    sm_rrow    = j_reg[POS_W-1:0];
                    sm_rcol    = i_reg[POS_W-1:0];
                    state_next = S_TB_T2;
                end
            end

            S_TB_T2:
            begin
                add_a = bm_b;
                add_b = TOTAL_W'(sm_rdata);
                if (bm_a == here_reg)
                begin
                    stk_ctrl.push       = 1'b1;
                    stk_ctrl.push_iv.lo = i_reg[POS_W-1:0];
                    stk_ctrl.push_iv.hi = jm1[POS_W-1:0];
                    state_next          = S_TB_POP;
                end
                else if (sum_eq_here)
                begin
                    pt_we               = 1'b1;
                    pt_waddr            = i_reg[POS_W-1:0];
                    pt_wdata            = j_reg[POS_W-1:0];
                    stk_ctrl.push       = 1'b1;
                    stk_ctrl.push_iv.lo = ip1[POS_W-1:0];
                    stk_ctrl.push_iv.hi = jm1[POS_W-1:0];
                    state_next          = S_TB_PAIR;
                end
                else
                begin
                    k_next     = ip1;
                    state_next = S_TB_SK;
                end
            end

            S_TB_PAIR:
            begin
                pt_we      = 1'b1;
                pt_waddr   = j_reg[POS_W-1:0];
                pt_wdata   = i_reg[POS_W-1:0];
                state_next = S_TB_POP;
            end

            // Split search: each candidate k is addressed in S_TB_SK and tested in S_TB_SPLIT.
            S_TB_SK:
            begin
                if (k_reg < j_reg)
                begin
                    bm_a_row   = k_reg[POS_W-1:0];
                    bm_a_col   = i_reg[POS_W-1:0];
                    bm_b_row   = j_reg[POS_W-1:0];
                    bm_b_col   = kp1[POS_W-1:0];
                    state_next = S_TB_SPLIT;
                end
                else
                begin
                    state_next = S_TB_POP;
                end
            end

            S_TB_SPLIT:
            begin
                add_a = bm_a;
                add_b = bm_b;
                if (sum_eq_here)
                begin
                    // Right part first so that the left part pops first.
                    // The left part (i, k) is pushed in the next step.
                    stk_ctrl.push       = 1'b1;
                    stk_ctrl.push_iv.lo = kp1[POS_W-1:0];
                    stk_ctrl.push_iv.hi = j_reg[POS_W-1:0];
                    j_next              = k_reg;
                    k_next              = LEN_W'(MAX_LEN);
                    state_next          = S_TB_SK;
                end
                else
                begin
                    k_next     = kp1;
                    state_next = S_TB_SK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Once a split is found the sequencer parks k beyond j and the next
        // S_TB_SK cycle pushes the left part (i, k) with j now holding k.
        if ((state_reg == S_TB_SK) && (k_reg == LEN_W'(MAX_LEN)))
        begin
            bm_a_row            = '0;
            bm_a_col            = '0;
            bm_b_row            = '0;
            bm_b_col            = '0;
            stk_ctrl.push       = 1'b1;
            stk_ctrl.push_iv.lo = i_reg[POS_W-1:0];
            stk_ctrl.push_iv.hi = j_reg[POS_W-1:0];
            state_next          = S_TB_POP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            run_length_reg <= '0;
            pt_valid_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            run_length_reg <= run_length_next;
            if (pt_clear)
            begin
                pt_valid_reg <= '0;
            end
            else if (pt_we)
            begin
                pt_valid_reg[pt_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg           <= j_next;
        i_reg           <= i_next;
        k_reg           <= k_next;
        len_reg         <= len_next;
        best_reg        <= best_next;
        acc_reg         <= acc_next;
        here_reg        <= here_next;
        total_reg       <= total_next;
        s_reg           <= s_next;
        q_row_reg       <= q_row_next;
        p_reg           <= p_next;
        hit_reg         <= hit_next;
        paired_reg      <= paired_next;
        partner_reg     <= partner_next;
        pair_score_reg  <= pair_score_next;
        total_score_reg <= total_score_next;
        done_res_reg    <= done_res_next;
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_rd_reg  <= pt_mem[pt_raddr];
        pt_vrd_reg <= pt_valid_reg[pt_raddr];
    end

    wbf_score_mem u_score_mem (
        .clk   (clk),
        .we    (sm_we),
        .wrow  (row),
        .wcol  (col),
        .wdata (score),
        .rrow  (sm_rrow),
        .rcol  (sm_rcol),
        .rdata (sm_rdata)
    );

    wbf_best_mem u_best_mem (
        .clk    (clk),
        .we     (bm_we),
        .wrow   (j_reg[POS_W-1:0]),
        .wcol   (i_reg[POS_W-1:0]),
        .wdata  (bm_wdata),
        .a_row  (bm_a_row),
        .a_col  (bm_a_col),
        .a_zero (bm_a_zero),
        .b_row  (bm_b_row),
        .b_col  (bm_b_col),
        .a_data (bm_a),
        .b_data (bm_b)
    );

    wbf_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stk_ctrl),
        .stat  (stk_stat)
    );

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign paired      = paired_reg;
    assign partner     = partner_reg;
    assign pair_score  = pair_score_reg;
    assign total_score = total_score_reg;
    assign done_res    = done_res_reg;

    // An accepted run always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_RUN)) |=> busy)
        else $error("run request did not start the sequencer");

    // An unknown command reports nothing but the strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !done_res_reg) |-> (!paired_reg && (total_score_reg == '0)))
        else $error("unknown command returned data");

    // The inner fill step only runs for split points below the loop gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_F_ADD) |-> ((k_reg + LEN_W'(MIN_LOOP)) < j_reg))
        else $error("fill step beyond the minimum loop");

endmodule

`default_nettype wire
